// ===== rtl/core/trm_pkg.sv =====
// shared types and codes for the toy register machine step unit
package trm_pkg;

    localparam int OPND_W = 5;
    localparam int PC_W   = 5;
    localparam int EXT_W  = 32;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_LOAD  = 4'd4;
    localparam logic [3:0] OP_STORE = 4'd5;
    localparam logic [3:0] OP_JUMP  = 4'd6;
    localparam logic [3:0] OP_BEQ   = 4'd7;
    localparam logic [3:0] OP_BPOS  = 4'd8;
    localparam logic [3:0] OP_BNEG  = 4'd9;
    localparam logic [3:0] OP_SHOW  = 4'd10;
    localparam logic [3:0] OP_ENTER = 4'd11;
    localparam logic [3:0] OP_HALT  = 4'd12;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIVZ  = 2'd1;
    localparam logic [1:0] ST_HALT  = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;

    typedef struct packed {
        logic [3:0]        opcode;
        logic [OPND_W-1:0] first_operand;
        logic [OPND_W-1:0] second_operand;
        logic [OPND_W-1:0] third_operand;
        logic signed [EXT_W-1:0] entered_value;
    } trm_in_t;

    typedef struct packed {
        logic [PC_W-1:0]         next_pc;
        logic [1:0]              status;
        logic signed [EXT_W-1:0] shown_value;
        logic                    show_valid;
    } trm_out_t;

    typedef struct packed {
        logic start;
        logic is_mul;
    } trm_md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trm_md_rsp_t;

endpackage

// ===== rtl/core/trm_ram.sv =====
// generic single-write, single-read ram with registered read data
module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/trm_muldiv.sv =====
// shared iterative unit: shift-add multiply and signed restoring divide, one bit per cycle
module trm_muldiv
    import trm_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  trm_md_req_t      req,
    input  logic [WIDTH-1:0] opa,
    input  logic [WIDTH-1:0] opb,
    output trm_md_rsp_t      rsp,
    output logic [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic             mul_reg;
    logic             neg_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;

    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] x_next;
    logic [WIDTH-1:0] y_next;
    logic [WIDTH-1:0] rem_sh;
    logic             ge;
    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;

    always_comb begin
        mag_a  = opa[WIDTH-1] ? ('0 - opa) : opa;
        mag_b  = opb[WIDTH-1] ? ('0 - opb) : opb;
        // remainder stays below the divisor, so its top bit is free for the shift
        rem_sh = {acc_reg[WIDTH-2:0], x_reg[WIDTH-1]};
        ge     = rem_sh >= y_reg;
        if (mul_reg) begin
            acc_next = y_reg[0] ? (acc_reg + x_reg) : acc_reg;
            x_next   = x_reg << 1;
            y_next   = y_reg >> 1;
        end else begin
            acc_next = ge ? (rem_sh - y_reg) : rem_sh;
            x_next   = {x_reg[WIDTH-2:0], ge};
            y_next   = y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CW'(WIDTH - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                mul_reg  <= req.is_mul;
                neg_reg  <= opa[WIDTH-1] ^ opb[WIDTH-1];
                cnt_reg  <= '0;
                acc_reg  <= '0;
                x_reg    <= req.is_mul ? opa : mag_a;
                y_reg    <= req.is_mul ? opb : mag_b;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                x_reg   <= x_next;
                y_reg   <= y_next;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign result   = mul_reg ? acc_reg : (neg_reg ? ('0 - x_reg) : x_reg);
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("muldiv started while busy");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !mul_reg) |-> (y_reg != '0))
        else $error("divide running with zero divisor");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("done without a preceding run");
`endif

endmodule

// ===== rtl/core/toy_register_machine_step_unit.sv =====
// top level of the toy register machine step unit: one instruction per input beat
// each beat passes S_RD_A, S_RD_B and S_EXEC to S_DONE; beats after halt go straight to S_DONE
// mul and div run through S_MD in the bit-serial muldiv unit, divide by zero through S_DZ
// a new beat is taken only in S_IDLE, once S_DONE has passed the previous result to the output register
// reset: synchronous active-low aresetn, then a clearing pass over max(DATA_WORDS, NUM_REGS) addresses
// zeroes both rams while s_ready stays low
module toy_register_machine_step_unit
    import trm_pkg::*;
#(
    parameter int DATA_WORDS = 32,
    parameter int NUM_REGS   = 4,
    parameter int WORD_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  trm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output trm_out_t m_data
);

    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int DATA_AW   = $clog2(DATA_WORDS);
    localparam int CLR_DEPTH = (DATA_WORDS > NUM_REGS) ? DATA_WORDS : NUM_REGS;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_EXEC,
        S_MD,
        S_DZ,
        S_DONE
    } state_t;

    // x mod n for a 5-bit x by conditional subtraction of n shifted down
    function automatic logic [OPND_W-1:0] mod_small(input logic [OPND_W-1:0] x,
                                                    input int unsigned n);
        logic [15:0] r;
        logic [15:0] m;
        r = 16'(x);
        for (int k = OPND_W - 1; k >= 0; k--) begin
            m = 16'(n << k);
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[OPND_W-1:0];
    endfunction

    function automatic logic signed [EXT_W-1:0] to_ext(input logic [WORD_WIDTH-1:0] w);
        return EXT_W'(signed'(w));
    endfunction

    state_t                state_reg;
    logic [CLR_AW-1:0]     clr_cnt_reg;
    logic [PC_W-1:0]       pc_reg;
    logic                  halted_reg;
    logic [3:0]            op_reg;
    logic [REG_AW-1:0]     rd_reg;
    logic [REG_AW-1:0]     ra_reg;
    logic [REG_AW-1:0]     rb_reg;
    logic [DATA_AW-1:0]    d1_reg;
    logic [DATA_AW-1:0]    d2_reg;
    logic [OPND_W-1:0]     f1_reg;
    logic [OPND_W-1:0]     f3_reg;
    logic [WORD_WIDTH-1:0] ent_reg;
    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] dm_reg;
    trm_out_t              res_reg;
    logic                  m_valid_reg;
    trm_out_t              m_data_reg;

    logic                  reg_we;
    logic [REG_AW-1:0]     reg_waddr;
    logic [WORD_WIDTH-1:0] reg_wdata;
    logic [REG_AW-1:0]     reg_raddr;
    logic [WORD_WIDTH-1:0] reg_rdata;
    logic                  dat_we;
    logic [DATA_AW-1:0]    dat_waddr;
    logic [WORD_WIDTH-1:0] dat_wdata;
    logic [DATA_AW-1:0]    dat_raddr;
    logic [WORD_WIDTH-1:0] dat_rdata;

    trm_md_req_t           md_req;
    trm_md_rsp_t           md_rsp;
    logic [WORD_WIDTH-1:0] md_result;

    logic [WORD_WIDTH-1:0] b_word;
    logic [WORD_WIDTH-1:0] alu_word;
    logic                  is_branch;
    logic                  taken;
    logic [PC_W-1:0]       pc_seq;
    trm_out_t              exec_res;
    state_t                exec_state;

    trm_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_reg_ram (
        .aclk  (aclk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    trm_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DATA_WORDS)
    ) u_dat_ram (
        .aclk  (aclk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    trm_muldiv #(
        .WIDTH (WORD_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .opa     (a_reg),
        .opb     (b_word),
        .rsp     (md_rsp),
        .result  (md_result)
    );

    // second register read lands straight from the ram output in S_EXEC
    assign b_word    = reg_rdata;
    assign alu_word  = (op_reg == OP_SUB) ? (a_reg - b_word) : (a_reg + b_word);
    assign is_branch = (op_reg == OP_BEQ) || (op_reg == OP_BPOS) || (op_reg == OP_BNEG);
    assign pc_seq    = pc_reg + PC_W'(1);

    always_comb begin
        unique case (op_reg) inside
            OP_BEQ:  taken = (a_reg == b_word);
            OP_BPOS: taken = (a_reg != '0) && !a_reg[WORD_WIDTH-1];
            OP_BNEG: taken = a_reg[WORD_WIDTH-1];
            default: taken = 1'b0;
        endcase
    end

    // result and next state of the execute cycle
    always_comb begin
        exec_res.next_pc     = pc_seq;
        exec_res.status      = ST_OK;
        exec_res.shown_value = '0;
        exec_res.show_valid  = 1'b0;
        exec_state           = S_DONE;
        unique case (op_reg) inside
            OP_ADD, OP_SUB: begin
                exec_res.shown_value = to_ext(alu_word);
                exec_res.show_valid  = 1'b1;
            end
            OP_MUL: exec_state = S_MD;
            OP_DIV: begin
                if (b_word == '0) begin
                    exec_res.status = ST_DIVZ;
                    exec_state      = S_DZ;
                end else begin
                    exec_state = S_MD;
                end
            end
            OP_LOAD, OP_SHOW: begin
                exec_res.shown_value = to_ext(dm_reg);
                exec_res.show_valid  = 1'b1;
            end
            OP_STORE, OP_ENTER: ;
            OP_JUMP: exec_res.next_pc = f1_reg;
            OP_BEQ, OP_BPOS, OP_BNEG: begin
                if (taken) begin
                    exec_res.next_pc = f3_reg;
                end
            end
            OP_HALT: begin
                exec_res.next_pc = pc_reg;
                exec_res.status  = ST_HALT;
            end
            default: begin
                exec_res.next_pc = pc_reg;
                exec_res.status  = ST_UNDEF;
            end
        endcase
    end

    always_comb begin
        reg_we    = 1'b0;
        reg_waddr = rd_reg;
        reg_wdata = alu_word;
        reg_raddr = ra_reg;
        dat_we    = 1'b0;
        dat_waddr = d1_reg;
        dat_wdata = a_reg;
        dat_raddr = d1_reg;
        md_req    = '0;
        unique case (state_reg)
            S_CLEAR: begin
                reg_we    = 32'(clr_cnt_reg) < NUM_REGS;
                reg_waddr = clr_cnt_reg[REG_AW-1:0];
                reg_wdata = '0;
                dat_we    = 32'(clr_cnt_reg) < DATA_WORDS;
                dat_waddr = clr_cnt_reg[DATA_AW-1:0];
                dat_wdata = '0;
            end
            S_RD_A: begin
                reg_raddr = is_branch ? rd_reg : ra_reg;
                dat_raddr = (op_reg == OP_LOAD) ? d2_reg : d1_reg;
            end
            S_RD_B: begin
                reg_raddr = (op_reg == OP_BEQ) ? ra_reg : rb_reg;
            end
            S_EXEC: begin
                // rd read ahead for the divide-by-zero case
                reg_raddr = rd_reg;
                unique case (op_reg) inside
                    OP_ADD, OP_SUB: reg_we = 1'b1;
                    OP_MUL: begin
                        md_req.start  = 1'b1;
                        md_req.is_mul = 1'b1;
                    end
                    OP_DIV: md_req.start = (b_word != '0);
                    OP_LOAD: begin
                        reg_we    = 1'b1;
                        reg_wdata = dm_reg;
                    end
                    OP_STORE: dat_we = 1'b1;
                    OP_ENTER: begin
                        dat_we    = 1'b1;
                        dat_wdata = ent_reg;
                    end
                    default: ;
                endcase
            end
            S_MD: begin
                reg_we    = md_rsp.done;
                reg_wdata = md_result;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
                    if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg  <= s_data.opcode;
                        rd_reg  <= REG_AW'(mod_small(s_data.first_operand, NUM_REGS));
                        ra_reg  <= REG_AW'(mod_small(s_data.second_operand, NUM_REGS));
                        rb_reg  <= REG_AW'(mod_small(s_data.third_operand, NUM_REGS));
                        d1_reg  <= DATA_AW'(mod_small(s_data.first_operand, DATA_WORDS));
                        d2_reg  <= DATA_AW'(mod_small(s_data.second_operand, DATA_WORDS));
                        f1_reg  <= s_data.first_operand;
                        f3_reg  <= s_data.third_operand;
                        ent_reg <= WORD_WIDTH'(s_data.entered_value);
                        if (halted_reg) begin
                            res_reg.next_pc     <= pc_reg;
                            res_reg.status      <= ST_HALT;
                            res_reg.shown_value <= '0;
                            res_reg.show_valid  <= 1'b0;
                            state_reg           <= S_DONE;
                        end else begin
                            state_reg <= S_RD_A;
                        end
                    end
                end
                S_RD_A: begin
                    state_reg <= S_RD_B;
                end
                S_RD_B: begin
                    a_reg     <= reg_rdata;
                    dm_reg    <= dat_rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_reg   <= exec_res;
                    state_reg <= exec_state;
                    if (op_reg == OP_HALT) begin
                        halted_reg <= 1'b1;
                    end
                end
                S_MD: begin
                    if (md_rsp.done) begin
                        res_reg.shown_value <= to_ext(md_result);
                        res_reg.show_valid  <= 1'b1;
                        state_reg           <= S_DONE;
                    end
                end
                S_DZ: begin
                    // unchanged destination is shown
                    res_reg.shown_value <= to_ext(reg_rdata);
                    res_reg.show_valid  <= 1'b1;
                    state_reg           <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        pc_reg      <= res_reg.next_pc;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!reg_we && !dat_we))
        else $error("ram write while idle");

    a_md_start_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        md_req.start |-> ((state_reg == S_EXEC) && ((op_reg == OP_MUL) || (op_reg == OP_DIV))))
        else $error("muldiv started outside execute");

    a_halted_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> $stable(pc_reg))
        else $error("pc moved after halt");

    a_halted_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && halted_reg) |=>
        ((state_reg == S_DONE) && (res_reg.status == ST_HALT) && !res_reg.show_valid))
        else $error("beat after halt not answered with halt status");
`endif

endmodule
